// ===== rtl/core/gost64_pkg.sv =====
// Shared types, constants and round function of the Magma block cipher core.
`default_nettype none

package gost64_pkg;

  localparam int unsigned NUM_ROUNDS     = 32;
  localparam int unsigned LAST_ROUND     = 31;
  localparam int unsigned FORWARD_ROUNDS = 24;
  localparam int unsigned KEY_WORDS      = 8;
  localparam int unsigned ROT_BITS       = 11;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned BLOCK_W        = 64;
  localparam int unsigned KEY_IDX_W      = 3;
  localparam int unsigned REG_INDEX_W    = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [0:KEY_WORDS-1][WORD_W-1:0] key_words_t;

  // Mode codes
  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } mode_t;

  // Data carried from one round stage to the next
  typedef struct packed {
    logic  mode;
    word_t left;
    word_t right;
  } stage_t;

  // Standard test key after reset
  localparam key_words_t KEY_RESET = '{
    32'hFFEEDDCC, 32'hBBAA9988, 32'h77665544, 32'h33221100,
    32'hF0F1F2F3, 32'hF4F5F6F7, 32'hF8F9FAFB, 32'hFCFDFEFF
  };

  // Box n serves nibble n (bits 4n+3..4n)
  localparam logic [3:0] SBOX [0:7][0:15] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // Substitute every nibble through its box
  function automatic word_t substitute(input word_t x);
    word_t y;
    y = '0;
    for (int n = 0; n < 8; n++) begin
      y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
    end
    return y;
  endfunction

  // Round function: key add, substitution, rotate left
  function automatic word_t round_f(input word_t right, input word_t key);
    word_t s;
    s = substitute(right + key);
    return (s << ROT_BITS) | (s >> (WORD_W - ROT_BITS));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gost64_if.sv =====
// Valid/ready channel interfaces for the input and result streams.
`default_nettype none

interface gost64_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] block_in;

  modport source (output valid, output mode, output block_in, input ready);
  modport sink   (input valid, input mode, input block_in, output ready);
endinterface

interface gost64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;

  modport source (output valid, output block_out, input ready);
  modport sink   (input valid, input block_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gost64_key_regs.sv =====
// Key register file written through the configuration port.
`default_nettype none

module gost64_key_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 write_en,
  input  wire logic [gost64_pkg::REG_INDEX_W-1:0]   reg_index,
  input  wire logic [gost64_pkg::WORD_W-1:0]        write_data,
  output gost64_pkg::key_words_t                    key_words
);

  gost64_pkg::key_words_t keys;

  // Load reset key, take writes to valid indexes, drop the rest
  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= gost64_pkg::KEY_RESET;
    end else if (write_en &&
                 (reg_index < gost64_pkg::REG_INDEX_W'(gost64_pkg::KEY_WORDS))) begin
      keys[reg_index[gost64_pkg::KEY_IDX_W-1:0]] <= write_data;
    end
  end

  assign key_words = keys;

endmodule

`default_nettype wire

// ===== rtl/core/gost64_round.sv =====
// One Feistel round with its pipeline register and stall control.
`default_nettype none

module gost64_round #(
  parameter int unsigned ROUND = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire gost64_pkg::key_words_t key_words,
  input  wire logic                   up_valid,
  output logic                        up_ready,
  input  wire gost64_pkg::stage_t     up_data,
  output logic                        dn_valid,
  input  wire logic                   dn_ready,
  output gost64_pkg::stage_t          dn_data
);

  // Key word picked by this round in each direction
  localparam logic [gost64_pkg::KEY_IDX_W-1:0] ENC_IDX =
    (ROUND < gost64_pkg::FORWARD_ROUNDS) ?
      gost64_pkg::KEY_IDX_W'(ROUND % gost64_pkg::KEY_WORDS) :
      gost64_pkg::KEY_IDX_W'(gost64_pkg::KEY_WORDS - 1 - ROUND % gost64_pkg::KEY_WORDS);
  localparam logic [gost64_pkg::KEY_IDX_W-1:0] DEC_IDX =
    (ROUND < gost64_pkg::NUM_ROUNDS - gost64_pkg::FORWARD_ROUNDS) ?
      gost64_pkg::KEY_IDX_W'(ROUND % gost64_pkg::KEY_WORDS) :
      gost64_pkg::KEY_IDX_W'(gost64_pkg::KEY_WORDS - 1 - ROUND % gost64_pkg::KEY_WORDS);
  localparam bit IS_LAST = (ROUND == gost64_pkg::LAST_ROUND);

  logic                   valid;
  gost64_pkg::stage_t     data;
  gost64_pkg::stage_t     data_next;
  gost64_pkg::word_t      key;
  gost64_pkg::word_t      mixed;

  // Select round key and mix
  always_comb begin
    key   = (up_data.mode == gost64_pkg::MODE_DECRYPT) ? key_words[DEC_IDX]
                                                        : key_words[ENC_IDX];
    mixed = up_data.left ^ gost64_pkg::round_f(up_data.right, key);
    data_next.mode = up_data.mode;
    if (IS_LAST) begin
      data_next.left  = mixed;
      data_next.right = up_data.right;
    end else begin
      data_next.left  = up_data.right;
      data_next.right = mixed;
    end
  end

  // Advance when this stage is empty or the next one takes its item
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

`default_nettype wire

// ===== rtl/core/gost_64bit_block_cipher_unit.sv =====
// Magma block cipher core: 32 round pipeline stages behind a key register file.
//
// Channels: in_ch takes a 64-bit block (left half in bits 63..32) and a
// mode bit (0 encrypt, 1 decrypt); out_ch delivers the 64-bit result.
// A transfer happens on a rising edge with valid and ready both high.
// The key is eight 32-bit words written through write_en/reg_index/
// write_data; indexes 8 and up are dropped. Change the key only while
// no block is in flight.
// Each block passes one stage per Feistel round, the last stage doubling
// as output register. Throughput: one block per cycle while the receiver
// takes results, set by the single round per stage.
// Reset (rst, synchronous) empties the pipeline and loads the standard
// test key. When the receiver stalls, the last stage holds its result
// and empty stages keep filling; input ready drops only once every
// stage holds a block.
`default_nettype none

module gost_64bit_block_cipher_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  gost64_in_if.sink                                in_ch,
  gost64_out_if.source                             out_ch,
  input  wire logic                                write_en,
  input  wire logic [gost64_pkg::REG_INDEX_W-1:0]  reg_index,
  input  wire logic [gost64_pkg::WORD_W-1:0]       write_data
);

  localparam int unsigned N = gost64_pkg::NUM_ROUNDS;

  gost64_pkg::key_words_t  key_words;
  logic                    chain_valid [0:N];
  logic                    chain_ready [0:N];
  gost64_pkg::stage_t      chain_data  [0:N];

  gost64_key_regs u_keys (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .key_words  (key_words)
  );

  // Feed the first round from the input channel
  assign chain_valid[0]      = in_ch.valid;
  assign chain_data[0].mode  = in_ch.mode;
  assign chain_data[0].left  = in_ch.block_in[gost64_pkg::BLOCK_W-1:gost64_pkg::WORD_W];
  assign chain_data[0].right = in_ch.block_in[gost64_pkg::WORD_W-1:0];
  assign in_ch.ready         = chain_ready[0];

  // Round stages
  for (genvar r = 0; r < N; r++) begin : g_round
    gost64_round #(
      .ROUND (r)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .key_words (key_words),
      .up_valid  (chain_valid[r]),
      .up_ready  (chain_ready[r]),
      .up_data   (chain_data[r]),
      .dn_valid  (chain_valid[r+1]),
      .dn_ready  (chain_ready[r+1]),
      .dn_data   (chain_data[r+1])
    );
  end

  // Drive the result channel from the last stage
  assign out_ch.valid     = chain_valid[N];
  assign out_ch.block_out = {chain_data[N].left, chain_data[N].right};
  assign chain_ready[N]   = out_ch.ready;

endmodule

`default_nettype wire

// ===== rtl/core/gost64_checker.sv =====
// Port-level checks on the cipher core, bound to the top level.
`default_nettype none

module gost64_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] block_out
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(block_out))
    else $error("stalled result changed or vanished");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A ready receiver lets the whole pipeline move
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while receiver is ready");

  // Input back-pressure only comes from a stalled, full output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without a stalled result");

endmodule

bind gost_64bit_block_cipher_unit gost64_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .block_out (out_ch.block_out)
);

`default_nettype wire

// ===== tb/gost64_checker.sv =====
// Block-cipher predictor and result checker that watches both channels of the core.
`timescale 1ns / 100ps

module gost64_tb_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  gost64_in_if                                    in_ch,
  gost64_out_if                                   out_ch,
  input  wire logic                               write_en,
  input  wire logic [gost64_pkg::REG_INDEX_W-1:0] reg_index,
  input  wire logic [gost64_pkg::WORD_W-1:0]      write_data,
  output int unsigned                             mismatches,
  output int unsigned                             blocks_in_flight,
  output int unsigned                             blocks_checked
);

  // One block in flight: what went in and what must come out
  typedef struct packed {
    logic        decrypt;
    logic [63:0] source;
    logic [63:0] want;
  } cipher_job_t;

  // Substitution boxes, box n serves nibble n
  localparam int BOX [8][16] = '{
    '{12, 4, 6, 2, 10, 5, 11, 9, 14, 8, 13, 7, 0, 3, 15, 1},
    '{6, 8, 2, 3, 9, 10, 5, 12, 1, 14, 4, 7, 11, 13, 0, 15},
    '{11, 3, 5, 8, 2, 15, 10, 13, 14, 1, 7, 4, 12, 9, 6, 0},
    '{12, 8, 2, 1, 13, 4, 15, 6, 7, 0, 10, 5, 3, 14, 9, 11},
    '{7, 15, 5, 10, 8, 1, 6, 13, 0, 9, 3, 14, 11, 4, 2, 12},
    '{5, 13, 15, 6, 9, 2, 12, 10, 11, 7, 8, 1, 4, 3, 14, 0},
    '{8, 14, 2, 5, 6, 9, 1, 12, 15, 4, 11, 0, 13, 10, 3, 7},
    '{1, 7, 14, 13, 0, 5, 8, 3, 4, 15, 10, 6, 9, 12, 11, 2}
  };

  // Standard test key loaded by reset
  localparam gost64_pkg::word_t KEY_INIT [8] = '{
    32'hFFEEDDCC, 32'hBBAA9988, 32'h77665544, 32'h33221100,
    32'hF0F1F2F3, 32'hF4F5F6F7, 32'hF8F9FAFB, 32'hFCFDFEFF
  };

  gost64_pkg::word_t key_file [8];
  cipher_job_t       due_blocks [$];

  initial begin
    mismatches       = 0;
    blocks_in_flight = 0;
    blocks_checked   = 0;
  end

  function automatic gost64_pkg::word_t box_layer(input gost64_pkg::word_t x);
    gost64_pkg::word_t y;
    for (int n = 0; n < 8; n++) begin
      y[4*n +: 4] = 4'(BOX[n][x[4*n +: 4]]);
    end
    return y;
  endfunction

  // Key add, substitute, rotate left by 11
  function automatic gost64_pkg::word_t round_mix(input gost64_pkg::word_t half,
                                                  input gost64_pkg::word_t subkey);
    gost64_pkg::word_t s;
    s = box_layer(half + subkey);
    return {s[20:0], s[31:21]};
  endfunction

  // Run all 32 rounds; decryption walks the key schedule backwards
  function automatic logic [63:0] magma_transform(input logic decrypt, input logic [63:0] blk);
    gost64_pkg::word_t l;
    gost64_pkg::word_t r;
    gost64_pkg::word_t m;
    int unsigned       step;
    int unsigned       idx;
    l = blk[63:32];
    r = blk[31:0];
    for (int i = 0; i < 32; i++) begin
      step = decrypt ? 31 - i : i;
      idx  = (step < 24) ? step % 8 : 31 - step;
      m    = l ^ round_mix(r, key_file[idx]);
      if (i < 31) begin
        l = r;
        r = m;
      end else begin
        l = m;
      end
    end
    return {l, r};
  endfunction

  always @(posedge clk) begin
    cipher_job_t job;
    if (rst) begin
      due_blocks.delete();
      for (int i = 0; i < 8; i++) key_file[i] = KEY_INIT[i];
    end else begin
      // Compare each result transfer against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (due_blocks.size() == 0) begin
          mismatches++;
          $display("%0t: result %h with no block outstanding", $time, out_ch.block_out);
        end else begin
          job = due_blocks.pop_front();
          blocks_checked++;
          if (out_ch.block_out !== job.want) begin
            mismatches++;
            $display("%0t: block_out mismatch (%s of %h): expected %h actual %h", $time,
                     job.decrypt ? "decrypt" : "encrypt", job.source, job.want,
                     out_ch.block_out);
          end
        end
      end
      // Predict each input transfer with the key as it stands now
      if (in_ch.valid && in_ch.ready) begin
        job.decrypt = in_ch.mode;
        job.source  = in_ch.block_in;
        job.want    = magma_transform(in_ch.mode, in_ch.block_in);
        due_blocks.push_back(job);
      end
      // Track key writes; indexes past the last key word are dropped
      if (write_en && reg_index < gost64_pkg::KEY_WORDS) key_file[reg_index[2:0]] = write_data;
    end
    blocks_in_flight = due_blocks.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the cipher core testbench: clock, reset, stimulus, key writes and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 40;

  // Corner blocks, each sent both ways; includes the standard test pair
  localparam logic [63:0] CORNER_BLOCKS [10] = '{
    64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h8000000000000000,
    64'h0000000000000001, 64'h00000000FFFFFFFF, 64'hFFFFFFFF00000000,
    64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 64'hFEDCBA9876543210,
    64'h4EE901E5C2D8CA3D
  };

  logic                               clk;
  logic                               rst;
  logic                               write_en;
  logic [gost64_pkg::REG_INDEX_W-1:0] reg_index;
  logic [gost64_pkg::WORD_W-1:0]      write_data;

  int unsigned mismatches;
  int unsigned blocks_in_flight;
  int unsigned blocks_checked;

  bit          tx_free;
  bit          rx_free;
  int unsigned burst_left;
  int unsigned rx_hold;
  int unsigned enc_sent;
  int unsigned dec_sent;
  int unsigned key_sets;
  int unsigned stray_writes;

  gost64_in_if  in_ch ();
  gost64_out_if out_ch ();

  gost_64bit_block_cipher_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data)
  );

  gost64_tb_checker chk (
    .clk              (clk),
    .rst              (rst),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .write_en         (write_en),
    .reg_index        (reg_index),
    .write_data       (write_data),
    .mismatches       (mismatches),
    .blocks_in_flight (blocks_in_flight),
    .blocks_checked   (blocks_checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: alternate ready and stall stretches, sometimes long stalls; always ready while rx_free is set
  always @(negedge clk) begin
    if (rx_free) begin
      out_ch.ready = 1'b1;
    end else if (rx_hold == 0) begin
      out_ch.ready = !out_ch.ready;
      if (out_ch.ready) begin
        rx_hold = $urandom_range(1, 16);
      end else begin
        rx_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      end
    end else begin
      rx_hold--;
    end
  end

  // Offer one block and hold it until the transfer; random gap between bursts unless tx_free is set
  task automatic send_block(input gost64_pkg::mode_t dir, input logic [63:0] blk);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = tx_free ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid    = 1'b1;
    in_ch.mode     = dir;
    in_ch.block_in = blk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (dir == gost64_pkg::MODE_DECRYPT) dec_sent++;
    else enc_sent++;
  endtask

  // Drop valid and wait until every block in flight has come back
  task automatic drain_pipe();
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (blocks_in_flight != 0) @(negedge clk);
  endtask

  task automatic write_key(input int unsigned idx, input gost64_pkg::word_t value);
    write_en   = 1'b1;
    reg_index  = gost64_pkg::REG_INDEX_W'(idx);
    write_data = value;
    @(negedge clk);
    write_en   = 1'b0;
  endtask

  // Random blocks, with a few halves pinned to all zeros or all ones
  task automatic send_random(input int unsigned count);
    logic [63:0]       blk;
    gost64_pkg::mode_t dir;
    for (int unsigned n = 0; n < count; n++) begin
      blk = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: blk[63:32] = '0;
        1: blk[31:0]  = '1;
        2: blk        = {32'hFFFFFFFF, blk[31:0]};
        default: ;
      endcase
      dir = $urandom_range(0, 1) ? gost64_pkg::MODE_DECRYPT : gost64_pkg::MODE_ENCRYPT;
      send_block(dir, blk);
    end
  endtask

  // Watchdog: end the run if no transfer happens for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Stalled for %0d cycles with %0d blocks outstanding", STALL_LIMIT,
             blocks_in_flight);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    gost64_pkg::word_t kw;
    rst            = 1'b1;
    write_en       = 1'b0;
    reg_index      = '0;
    write_data     = '0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = gost64_pkg::MODE_ENCRYPT;
    in_ch.block_in = '0;
    out_ch.ready   = 1'b0;
    tx_free        = 1'b0;
    rx_free        = 1'b0;
    burst_left     = 0;
    rx_hold        = 0;
    enc_sent       = 0;
    dec_sent       = 0;
    key_sets       = 1;
    stray_writes   = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Reset key: corner blocks both ways, then random traffic
    for (int i = 0; i < 10; i++) begin
      send_block(gost64_pkg::MODE_ENCRYPT, CORNER_BLOCKS[i]);
      send_block(gost64_pkg::MODE_DECRYPT, CORNER_BLOCKS[i]);
    end
    send_random(60);
    drain_pipe();

    // All-zero key at full rate on both sides
    for (int i = 0; i < gost64_pkg::KEY_WORDS; i++) write_key(i, '0);
    key_sets++;
    tx_free = 1'b1;
    rx_free = 1'b1;
    send_random(60);
    drain_pipe();
    tx_free = 1'b0;
    rx_free = 1'b0;

    // All-ones key
    for (int i = 0; i < gost64_pkg::KEY_WORDS; i++) write_key(i, '1);
    key_sets++;
    send_random(60);
    drain_pipe();

    // Random keys; stray writes above the last key word must change nothing
    for (int p = 0; p < 4; p++) begin
      write_key($urandom_range(gost64_pkg::KEY_WORDS, 2**gost64_pkg::REG_INDEX_W - 1),
                $urandom);
      stray_writes++;
      for (int i = 0; i < gost64_pkg::KEY_WORDS; i++) begin
        kw = $urandom;
        case ($urandom_range(0, 7))
          0: kw = '0;
          1: kw = '1;
          default: ;
        endcase
        write_key(i, kw);
      end
      write_key(2**gost64_pkg::REG_INDEX_W - 1, $urandom);
      stray_writes++;
      key_sets++;
      send_random(55);
      drain_pipe();
    end

    // Hold for the pipeline depth to catch any late result
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Covered %0d blocks (%0d encrypt, %0d decrypt) over %0d key settings",
             enc_sent + dec_sent, enc_sent, dec_sent, key_sets);
    $display("Compared %0d results; %0d writes to unused indexes; %0d mismatches",
             blocks_checked, stray_writes, mismatches);
    if (mismatches == 0 && blocks_in_flight == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
